>>> design/mpt_pkg.sv
`timescale 1ns / 1ps

package mpt_pkg;

    localparam int TABLE_ENTRIES = 64;
    localparam int NUM_PORTS     = 16;
    localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
    localparam int VID_W         = 12;
    localparam int MAC_W         = 48;
    localparam int KEY_W         = VID_W + MAC_W;
    localparam int PORT_W        = 4;
    localparam int GROUP_BIT     = 40;

    typedef logic [KEY_W-1:0]     key_t;
    typedef logic [NUM_PORTS-1:0] mask_t;
    typedef logic [IDX_W-1:0]     idx_t;

    localparam logic [1:0] OP_LOOKUP = 2'd0;
    localparam logic [1:0] OP_ADD    = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;
    localparam logic [1:0] OP_CLEAR  = 2'd3;

    localparam logic [2:0] ST_OK            = 3'd0;
    localparam logic [2:0] ST_PORT_PRESENT  = 3'd1;
    localparam logic [2:0] ST_ENTRY_MISSING = 3'd2;
    localparam logic [2:0] ST_PORT_MISSING  = 3'd3;
    localparam logic [2:0] ST_FULL          = 3'd4;
    localparam logic [2:0] ST_NOT_MULTICAST = 3'd5;

    typedef struct packed {
        logic  en;
        idx_t  addr;
        key_t  key;
        mask_t ports;
    } mpt_wr_t;

endpackage

>>> design/multicast_port_table.sv
`timescale 1ns / 1ps
// clear and non-multicast transactions: result strobe in the cycle after start is taken
// lookup, add and remove: one pass over the entries, ending at the first key match, through a single key comparator fed
// by the entry memory read port, then a decide state that registers the result and its strobe
// busy stays high until the result is registered; a new start is taken in the strobe cycle
// the receiver cannot stall; rst_n clears all entries (valid bits) and the sequencer at once

module multicast_port_table (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  operation,
    input  logic [11:0] vlan_id,
    input  logic [47:0] mac_address,
    input  logic [3:0]  port_index,
    output logic        done,
    output logic [15:0] port_mask,
    output logic        hit,
    output logic [2:0]  status
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_DECIDE = 2'd2;

    localparam logic [mpt_pkg::CNT_W-1:0] CNT_END = mpt_pkg::CNT_W'(mpt_pkg::TABLE_ENTRIES);
    localparam logic [mpt_pkg::PORT_W:0]  PORT_LIM = (mpt_pkg::PORT_W + 1)'(mpt_pkg::NUM_PORTS);

    logic [1:0]                         state_reg, state_next;
    logic [mpt_pkg::TABLE_ENTRIES-1:0]  valid_reg, valid_next;
    logic [mpt_pkg::CNT_W-1:0]          cnt_reg, cnt_next;
    logic                               pend_reg, pend_next;
    mpt_pkg::idx_t                      pend_idx_reg, pend_idx_next;
    logic                               match_reg, match_next;
    mpt_pkg::idx_t                      match_idx_reg, match_idx_next;
    mpt_pkg::mask_t                     match_ports_reg, match_ports_next;
    logic                               free_reg, free_next;
    mpt_pkg::idx_t                      free_idx_reg, free_idx_next;
    logic                               done_reg, done_next;
    logic [1:0]                         op_reg, op_next;
    mpt_pkg::key_t                      key_reg, key_next;
    logic [mpt_pkg::PORT_W-1:0]         port_reg, port_next;
    mpt_pkg::mask_t                     mask_out_reg, mask_out_next;
    logic                               hit_reg, hit_next;
    logic [2:0]                         status_reg, status_next;

    mpt_pkg::mpt_wr_t wr;
    mpt_pkg::idx_t    issue_idx;
    mpt_pkg::key_t    rd_key;
    mpt_pkg::mask_t   rd_ports;
    mpt_pkg::mask_t   port_bit;
    logic             port_ok;
    logic             key_hit;

    assign issue_idx = cnt_reg[mpt_pkg::IDX_W-1:0];
    assign key_hit   = pend_reg && valid_reg[pend_idx_reg] && (rd_key == key_reg);
    assign port_bit  = mpt_pkg::mask_t'(1) << port_reg;
    assign port_ok   = {1'b0, port_reg} < PORT_LIM;

    mpt_ram u_ram (
        .clk      (clk),
        .wr       (wr),
        .rd_addr  (issue_idx),
        .rd_key   (rd_key),
        .rd_ports (rd_ports)
    );

    always_comb
    begin
        state_next       = state_reg;
        valid_next       = valid_reg;
        cnt_next         = cnt_reg;
        pend_next        = 1'b0;
        pend_idx_next    = issue_idx;
        match_next       = match_reg;
        match_idx_next   = match_idx_reg;
        match_ports_next = match_ports_reg;
        free_next        = free_reg;
        free_idx_next    = free_idx_reg;
        done_next        = 1'b0;
        op_next          = op_reg;
        key_next         = key_reg;
        port_next        = port_reg;
        mask_out_next    = mask_out_reg;
        hit_next         = hit_reg;
        status_next      = status_reg;
        wr.en            = 1'b0;
        wr.addr          = match_idx_reg;
        wr.key           = key_reg;
        wr.ports         = match_ports_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next       = operation;
                    key_next      = {vlan_id, mac_address};
                    port_next     = port_index;
                    mask_out_next = '0;
                    hit_next      = 1'b0;
                    status_next   = mpt_pkg::ST_OK;
                    if (operation == mpt_pkg::OP_CLEAR)
                    begin
                        valid_next = '0;
                        done_next  = 1'b1;
                    end
                    else if (!mac_address[mpt_pkg::GROUP_BIT])
                    begin
                        status_next = mpt_pkg::ST_NOT_MULTICAST;
                        done_next   = 1'b1;
                    end
                    else
                    begin
                        cnt_next   = '0;
                        match_next = 1'b0;
                        free_next  = 1'b0;
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (key_hit)
                begin
                    match_next       = 1'b1;
                    match_idx_next   = pend_idx_reg;
                    match_ports_next = rd_ports;
                    state_next       = S_DECIDE;
                end
                else if (cnt_reg != CNT_END)
                begin
                    pend_next = 1'b1;
                    cnt_next  = cnt_reg + 1'b1;
                    if (!free_reg && !valid_reg[issue_idx])
                    begin
                        free_next     = 1'b1;
                        free_idx_next = issue_idx;
                    end
                end
                else if (!pend_reg)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                state_next  = S_IDLE;
                done_next   = 1'b1;
                hit_next    = match_reg;
                mask_out_next = match_reg ? match_ports_reg : '0;
                status_next = mpt_pkg::ST_OK;
                if (op_reg != mpt_pkg::OP_LOOKUP && !port_ok)
                begin
                    status_next = mpt_pkg::ST_PORT_MISSING;
                end
                else
                begin
                    case (op_reg)
                        mpt_pkg::OP_ADD:
                        begin
                            if (!match_reg)
                            begin
                                if (free_reg)
                                begin
                                    wr.en                   = 1'b1;
                                    wr.addr                 = free_idx_reg;
                                    wr.ports                = port_bit;
                                    valid_next[free_idx_reg] = 1'b1;
                                    mask_out_next           = port_bit;
                                    hit_next                = 1'b1;
                                end
                                else
                                begin
                                    status_next = mpt_pkg::ST_FULL;
                                end
                            end
                            else if ((match_ports_reg & port_bit) != '0)
                            begin
                                status_next = mpt_pkg::ST_PORT_PRESENT;
                            end
                            else
                            begin
                                wr.en         = 1'b1;
                                wr.ports      = match_ports_reg | port_bit;
                                mask_out_next = match_ports_reg | port_bit;
                            end
                        end
                        mpt_pkg::OP_REMOVE:
                        begin
                            if (!match_reg)
                            begin
                                status_next = mpt_pkg::ST_ENTRY_MISSING;
                            end
                            else if ((match_ports_reg & port_bit) == '0)
                            begin
                                status_next = mpt_pkg::ST_PORT_MISSING;
                            end
                            else
                            begin
                                wr.en         = 1'b1;
                                wr.ports      = match_ports_reg & ~port_bit;
                                mask_out_next = match_ports_reg & ~port_bit;
                            end
                        end
                        default:
                        begin
                            status_next = mpt_pkg::ST_OK;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            valid_reg <= '0;
            cnt_reg   <= '0;
            pend_reg  <= 1'b0;
            match_reg <= 1'b0;
            free_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            cnt_reg   <= cnt_next;
            pend_reg  <= pend_next;
            match_reg <= match_next;
            free_reg  <= free_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_idx_reg    <= pend_idx_next;
        match_idx_reg   <= match_idx_next;
        match_ports_reg <= match_ports_next;
        free_idx_reg    <= free_idx_next;
        op_reg          <= op_next;
        key_reg         <= key_next;
        port_reg        <= port_next;
        mask_out_reg    <= mask_out_next;
        hit_reg         <= hit_next;
        status_reg      <= status_next;
    end

    assign busy      = (state_reg != S_IDLE);
    assign done      = done_reg;
    assign port_mask = mask_out_reg;
    assign hit       = hit_reg;
    assign status    = status_reg;

endmodule

>>> design/mpt_ram.sv
`timescale 1ns / 1ps

module mpt_ram (
    input  logic             clk,
    input  mpt_pkg::mpt_wr_t wr,
    input  mpt_pkg::idx_t    rd_addr,
    output mpt_pkg::key_t    rd_key,
    output mpt_pkg::mask_t   rd_ports
);

    mpt_pkg::key_t  key_mem   [mpt_pkg::TABLE_ENTRIES];
    mpt_pkg::mask_t ports_mem [mpt_pkg::TABLE_ENTRIES];
    mpt_pkg::key_t  rd_key_reg;
    mpt_pkg::mask_t rd_ports_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            key_mem[wr.addr]   <= wr.key;
            ports_mem[wr.addr] <= wr.ports;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_key_reg   <= key_mem[rd_addr];
        rd_ports_reg <= ports_mem[rd_addr];
    end

    assign rd_key   = rd_key_reg;
    assign rd_ports = rd_ports_reg;

endmodule

>>> dv/multicast_port_table_checker.sv
`timescale 1ns / 1ps

module multicast_port_table_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [1:0]  operation,
    input  logic [11:0] vlan_id,
    input  logic [47:0] mac_address,
    input  logic [3:0]  port_index,
    input  logic        done,
    input  logic [15:0] port_mask,
    input  logic        hit,
    input  logic [2:0]  status,
    output int          errors,
    output int          outstanding,
    output int          replies_checked,
    output logic [7:0]  status_seen
);

    typedef struct packed {
        mpt_pkg::mask_t mask;
        logic           hit;
        logic [2:0]     status;
    } reply_t;

    // shadow copy of the forwarding table
    bit             slot_valid [mpt_pkg::TABLE_ENTRIES];
    mpt_pkg::key_t  slot_key   [mpt_pkg::TABLE_ENTRIES];
    mpt_pkg::mask_t slot_ports [mpt_pkg::TABLE_ENTRIES];

    reply_t pending_replies [$];
    reply_t want;
    reply_t predicted;

    // runs one command against the shadow table and returns the reply it must produce
    function automatic reply_t apply_command(logic [1:0] op, logic [11:0] vid,
                                             logic [47:0] mac, logic [3:0] port);
        reply_t         r;
        mpt_pkg::key_t  k;
        int             idx;
        mpt_pkg::mask_t port_bit;
        r   = '0;
        k   = {vid, mac};
        idx = -1;
        if (op == mpt_pkg::OP_CLEAR)
        begin
            for (int i = 0; i < mpt_pkg::TABLE_ENTRIES; i++)
                slot_valid[i] = 1'b0;
            r.status = mpt_pkg::ST_OK;
            return r;
        end
        if (!mac[mpt_pkg::GROUP_BIT])
        begin
            r.status = mpt_pkg::ST_NOT_MULTICAST;
            return r;
        end
        for (int i = 0; i < mpt_pkg::TABLE_ENTRIES; i++)
            if (idx < 0 && slot_valid[i] && slot_key[i] == k)
                idx = i;
        if (idx >= 0)
        begin
            r.hit  = 1'b1;
            r.mask = slot_ports[idx];
        end
        r.status = mpt_pkg::ST_OK;
        if (op == mpt_pkg::OP_LOOKUP)
            return r;
        if (int'(port) >= mpt_pkg::NUM_PORTS)
        begin
            r.status = mpt_pkg::ST_PORT_MISSING;
            return r;
        end
        port_bit = mpt_pkg::mask_t'(1) << port;
        if (op == mpt_pkg::OP_ADD)
        begin
            if (idx < 0)
            begin
                // new entry goes to the lowest free slot
                for (int i = mpt_pkg::TABLE_ENTRIES - 1; i >= 0; i--)
                    if (!slot_valid[i])
                        idx = i;
                if (idx < 0)
                begin
                    r.status = mpt_pkg::ST_FULL;
                    return r;
                end
                slot_valid[idx] = 1'b1;
                slot_key[idx]   = k;
                slot_ports[idx] = port_bit;
                r.hit  = 1'b1;
                r.mask = port_bit;
                return r;
            end
            if ((slot_ports[idx] & port_bit) != '0)
                r.status = mpt_pkg::ST_PORT_PRESENT;
            else
            begin
                slot_ports[idx] = slot_ports[idx] | port_bit;
                r.mask = slot_ports[idx];
            end
            return r;
        end
        // remove; an emptied entry stays valid
        if (idx < 0)
        begin
            r.status = mpt_pkg::ST_ENTRY_MISSING;
            return r;
        end
        if ((slot_ports[idx] & port_bit) == '0)
            r.status = mpt_pkg::ST_PORT_MISSING;
        else
        begin
            slot_ports[idx] = slot_ports[idx] & ~port_bit;
            r.mask = slot_ports[idx];
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < mpt_pkg::TABLE_ENTRIES; i++)
                slot_valid[i] = 1'b0;
            pending_replies.delete();
            errors          = 0;
            outstanding     = 0;
            replies_checked = 0;
            status_seen     = '0;
        end
        else
        begin
            if (done)
            begin
                if (pending_replies.size() == 0)
                begin
                    $error("reply strobe with no transaction outstanding");
                    errors++;
                end
                else
                begin
                    want = pending_replies.pop_front();
                    replies_checked++;
                    if (status inside {[0:7]})
                        status_seen[status] = 1'b1;
                    if (port_mask !== want.mask)
                    begin
                        $error("port_mask: expected %h, actual %h", want.mask, port_mask);
                        errors++;
                    end
                    if (hit !== want.hit)
                    begin
                        $error("hit: expected %b, actual %b", want.hit, hit);
                        errors++;
                    end
                    if (status !== want.status)
                    begin
                        $error("status: expected %0d, actual %0d", want.status, status);
                        errors++;
                    end
                end
            end
            if (start && !busy)
            begin
                predicted = apply_command(operation, vlan_id, mac_address, port_index);
                pending_replies.insert(pending_replies.size(), predicted);
            end
            outstanding = pending_replies.size();
        end
    end

endmodule

>>> dv/multicast_port_table_test.sv
`timescale 1ns / 1ps

module multicast_port_table_test;

    localparam int TOTAL_COMMANDS = 450;
    localparam int POOL_SIZE      = 72;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  operation;
    logic [11:0] vlan_id;
    logic [47:0] mac_address;
    logic [3:0]  port_index;
    logic        done;
    logic [15:0] port_mask;
    logic        hit;
    logic [2:0]  status;

    int          error_count;
    int          pending_count;
    int          checked_count;
    logic [7:0]  statuses;

    int          sent;
    bit          quiet_stretch;
    logic [11:0] pool_vid [POOL_SIZE];
    logic [47:0] pool_mac [POOL_SIZE];

    multicast_port_table u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .operation   (operation),
        .vlan_id     (vlan_id),
        .mac_address (mac_address),
        .port_index  (port_index),
        .done        (done),
        .port_mask   (port_mask),
        .hit         (hit),
        .status      (status)
    );

    multicast_port_table_checker u_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .operation       (operation),
        .vlan_id         (vlan_id),
        .mac_address     (mac_address),
        .port_index      (port_index),
        .done            (done),
        .port_mask       (port_mask),
        .hit             (hit),
        .status          (status),
        .errors          (error_count),
        .outstanding     (pending_count),
        .replies_checked (checked_count),
        .status_seen     (statuses)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    initial
    begin
        #500_000;
        $display("multicast_port_table_test NOT OK");
        $finish;
    end

    // one transaction: random idle gap, then hold start until the block takes it
    task automatic issue(input logic [1:0] op, input logic [11:0] vid,
                         input logic [47:0] mac, input logic [3:0] port);
        int gap;
        gap = quiet_stretch ? 0 : $urandom_range(0, 8);
        repeat (gap)
        begin
            @(negedge clk);
            start       = 1'b0;
            operation   = 2'($urandom());
            vlan_id     = 12'($urandom());
            mac_address = 48'({$urandom(), $urandom()});
            port_index  = 4'($urandom());
        end
        @(negedge clk);
        start       = 1'b1;
        operation   = op;
        vlan_id     = vid;
        mac_address = mac;
        port_index  = port;
        do
            @(posedge clk);
        while (busy);
        sent++;
        if (sent % 32 == 0)
            quiet_stretch = ($urandom_range(0, 2) == 0);
    endtask

    task automatic pool_command(input logic [1:0] op, input int sel);
        issue(op, pool_vid[sel], pool_mac[sel], 4'($urandom()));
    endtask

    initial
    begin
        int          pick;
        logic [47:0] plain_mac;
        rst_n         = 1'b0;
        start         = 1'b0;
        operation     = mpt_pkg::OP_LOOKUP;
        vlan_id       = '0;
        mac_address   = '0;
        port_index    = '0;
        sent          = 0;
        quiet_stretch = 1'b0;

        // keys that differ only in vlan or in one low mac bit sit close together in the pool
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            pool_vid[i] = 12'($urandom());
            pool_mac[i] = 48'({$urandom(), $urandom()});
            if (i % 4 == 1)
            begin
                pool_mac[i] = pool_mac[i-1];
                pool_vid[i] = pool_vid[i-1] ^ 12'($urandom_range(1, 4095));
            end
            else if (i % 4 == 2)
            begin
                pool_mac[i] = pool_mac[i-2] ^ (48'd1 << $urandom_range(0, 39));
                pool_vid[i] = pool_vid[i-2];
            end
            pool_mac[i][mpt_pkg::GROUP_BIT] = 1'b1;
        end

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: key extremes, every status but full, emptied entry, clear
        issue(mpt_pkg::OP_LOOKUP, 12'h000, 48'hFFFF_FFFF_FFFF, 4'd0);
        issue(mpt_pkg::OP_REMOVE, 12'h000, 48'hFFFF_FFFF_FFFF, 4'd0);
        issue(mpt_pkg::OP_ADD,    12'h000, 48'hFFFF_FFFF_FFFF, 4'd0);
        issue(mpt_pkg::OP_ADD,    12'h000, 48'hFFFF_FFFF_FFFF, 4'd0);
        issue(mpt_pkg::OP_ADD,    12'h000, 48'hFFFF_FFFF_FFFF, 4'd15);
        issue(mpt_pkg::OP_LOOKUP, 12'h000, 48'hFFFF_FFFF_FFFF, 4'd9);
        issue(mpt_pkg::OP_LOOKUP, 12'hFFF, 48'hFFFF_FFFF_FFFF, 4'd0);
        issue(mpt_pkg::OP_ADD,    12'hFFF, 48'h0100_0000_0000, 4'd7);
        issue(mpt_pkg::OP_REMOVE, 12'h000, 48'hFFFF_FFFF_FFFF, 4'd3);
        issue(mpt_pkg::OP_REMOVE, 12'h000, 48'hFFFF_FFFF_FFFF, 4'd0);
        issue(mpt_pkg::OP_REMOVE, 12'h000, 48'hFFFF_FFFF_FFFF, 4'd15);
        issue(mpt_pkg::OP_LOOKUP, 12'h000, 48'hFFFF_FFFF_FFFF, 4'd0);
        issue(mpt_pkg::OP_ADD,    12'h000, 48'hFFFF_FFFF_FFFF, 4'd3);
        issue(mpt_pkg::OP_LOOKUP, 12'h000, 48'hFEFF_FFFF_FFFF, 4'd15);
        issue(mpt_pkg::OP_ADD,    12'hFFF, 48'h0000_0000_0000, 4'd15);
        issue(mpt_pkg::OP_REMOVE, 12'hABC, 48'hFEFF_FFFF_FFFF, 4'd0);
        issue(mpt_pkg::OP_CLEAR,  12'hFFF, 48'h0000_0000_0000, 4'd15);
        issue(mpt_pkg::OP_LOOKUP, 12'hFFF, 48'h0100_0000_0000, 4'd7);
        issue(mpt_pkg::OP_ADD,    12'hFFF, 48'hFFFF_FFFF_FFFF, 4'd15);
        issue(mpt_pkg::OP_ADD,    12'hFFF, 48'h0100_0000_0000, 4'd0);
        issue(mpt_pkg::OP_LOOKUP, 12'hFFF, 48'hFFFF_FFFF_FFFF, 4'd1);

        // fill the table past its capacity
        issue(mpt_pkg::OP_CLEAR, 12'($urandom()), 48'({$urandom(), $urandom()}),
              4'($urandom()));
        for (int i = 0; i < mpt_pkg::TABLE_ENTRIES + 2; i++)
            pool_command(mpt_pkg::OP_ADD, i);
        for (int i = 0; i < 6; i++)
            pool_command(mpt_pkg::OP_LOOKUP, $urandom_range(0, POOL_SIZE - 1));

        // hold off until the block has drained
        @(negedge clk);
        start = 1'b0;
        wait (pending_count == 0);

        while (sent < TOTAL_COMMANDS)
        begin
            pick = $urandom_range(0, 99);
            if (sent % 97 == 50)
            begin
                @(negedge clk);
                start = 1'b0;
                wait (pending_count == 0);
            end
            if (pick < 2)
                issue(mpt_pkg::OP_CLEAR, 12'($urandom()), 48'({$urandom(), $urandom()}),
                      4'($urandom()));
            else if (pick < 8)
            begin
                plain_mac = 48'({$urandom(), $urandom()});
                plain_mac[mpt_pkg::GROUP_BIT] = 1'b0;
                issue(2'($urandom_range(0, 2)), 12'($urandom()), plain_mac, 4'($urandom()));
            end
            else if (pick < 33)
                pool_command(mpt_pkg::OP_LOOKUP, $urandom_range(0, POOL_SIZE - 1));
            else if (pick < 70)
                pool_command(mpt_pkg::OP_ADD, $urandom_range(0, POOL_SIZE - 1));
            else
                pool_command(mpt_pkg::OP_REMOVE, $urandom_range(0, POOL_SIZE - 1));
        end

        @(negedge clk);
        start = 1'b0;
        wait (pending_count == 0);
        repeat (mpt_pkg::TABLE_ENTRIES + 8) @(posedge clk);

        $display("%0d transactions sent, %0d replies checked", sent, checked_count);
        $display("status codes observed (bit per code): %b", statuses);
        if (error_count == 0)
            $display("multicast_port_table_test OK");
        else
            $display("multicast_port_table_test NOT OK");
        $finish;
    end

endmodule
